FILE: sv/cle_pkg.sv
// Shared constants for the compacting list engine: command codes,
// status codes, field widths and the default capacity. No dependencies.
package cle_pkg;

  localparam int DEF_CAPACITY = 64;

  localparam int FUNC_W  = 3;
  localparam int POS_W   = 6;
  localparam int ENDP_W  = 7;
  localparam int DATA_W  = 64;
  localparam int STAT_W  = 2;
  localparam int CNT_W   = 7;

  localparam logic [FUNC_W-1:0] FUNC_APPEND    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ      = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_WRITE     = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE    = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR     = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE_RG = 3'd5;

  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OOB  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

endpackage

FILE: sv/compacting_list_engine.sv
// Compacting list engine: packed ordered list of 64-bit words in one RAM.
// Depends on cle_pkg.
//
// Usage:
//   A request (in_func, in_position, in_end_position, in_new_value) is taken
//   at a clock edge with start high and busy low. Exactly one result follows
//   on out_read_value, out_status and out_entry_count, marked by a one-cycle
//   out_valid strobe; the receiver cannot stall and must take it then.
//   Steps per function:
//     append, write, clear, bad index, unused code: result in the next cycle,
//       busy never rises.
//     read: registered RAM read (state RDW), then the registered result.
//     remove one: RAM read of the entry (RDW), then the tail shift (SHIFT).
//     remove range: straight to the tail shift (SHIFT) from end_position.
//   Removals move the tail through the single RAM port pair, one entry per
//   cycle, with the read of the next entry overlapping the write of the last.
//   A new request may be taken in the cycle its predecessor's result shows.
//   Reset: count clears to zero and the block is idle at once; RAM contents
//   are left as they are, since slots at or above count are never read.
module compacting_list_engine #(
  parameter int CAPACITY = cle_pkg::DEF_CAPACITY
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [cle_pkg::FUNC_W-1:0]  in_func,
  input  logic [cle_pkg::POS_W-1:0]   in_position,
  input  logic [cle_pkg::ENDP_W-1:0]  in_end_position,
  input  logic [cle_pkg::DATA_W-1:0]  in_new_value,
  output logic                        out_valid,
  output logic [cle_pkg::DATA_W-1:0]  out_read_value,
  output logic [cle_pkg::STAT_W-1:0]  out_status,
  output logic [cle_pkg::CNT_W-1:0]   out_entry_count
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CW > cle_pkg::ENDP_W) ? CW : cle_pkg::ENDP_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RDW   = 2'd1;
  localparam logic [1:0] ST_SHIFT = 2'd2;

  logic [1:0]                       state_r, state_nxt;
  logic [CW-1:0]                    count_r, count_nxt;
  logic [cle_pkg::FUNC_W-1:0]       op_r, op_nxt;
  logic [IW-1:0]                    src_r, src_nxt;
  logic [IW-1:0]                    dst_r, dst_nxt;
  logic                             pend_r, pend_nxt;
  logic [cle_pkg::DATA_W-1:0]       rv_r, rv_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [cle_pkg::DATA_W-1:0]       out_rv_r, out_rv_nxt;
  logic [cle_pkg::STAT_W-1:0]       out_st_r, out_st_nxt;
  logic [cle_pkg::CNT_W-1:0]        out_cnt_r, out_cnt_nxt;

  logic [cle_pkg::DATA_W-1:0]       mem [CAPACITY];
  logic [cle_pkg::DATA_W-1:0]       q_r;
  logic                             we, re;
  logic [AW-1:0]                    waddr, raddr;
  logic [cle_pkg::DATA_W-1:0]       wdata;

  logic [IW-1:0] pos_w, endp_w, cnt_w, cap_w;
  logic          accept, src_live;

  assign pos_w    = IW'(in_position);
  assign endp_w   = IW'(in_end_position);
  assign cnt_w    = IW'(count_r);
  assign cap_w    = IW'(CAPACITY);
  assign accept   = start && (state_r == ST_IDLE);
  assign src_live = src_r < cnt_w;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    op_nxt        = op_r;
    src_nxt       = src_r;
    dst_nxt       = dst_r;
    pend_nxt      = 1'b0;
    rv_nxt        = rv_r;
    out_valid_nxt = 1'b0;
    out_rv_nxt    = out_rv_r;
    out_st_nxt    = out_st_r;
    out_cnt_nxt   = out_cnt_r;
    we            = 1'b0;
    waddr         = pos_w[AW-1:0];
    wdata         = in_new_value;
    re            = 1'b0;
    raddr         = pos_w[AW-1:0];

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt        = in_func;
          out_valid_nxt = 1'b1;
          out_rv_nxt    = '0;
          out_st_nxt    = cle_pkg::STAT_OK;
          out_cnt_nxt   = cle_pkg::CNT_W'(count_r);
          case (in_func)
            cle_pkg::FUNC_APPEND: begin
              if (cnt_w >= cap_w) begin
                out_st_nxt = cle_pkg::STAT_FULL;
              end else begin
                we          = 1'b1;
                waddr       = cnt_w[AW-1:0];
                count_nxt   = count_r + 1'b1;
                out_cnt_nxt = cle_pkg::CNT_W'(cnt_w + 1'b1);
              end
            end
            cle_pkg::FUNC_READ, cle_pkg::FUNC_REMOVE: begin
              if (pos_w >= cnt_w) begin
                out_st_nxt = cle_pkg::STAT_OOB;
              end else begin
                re            = 1'b1;
                dst_nxt       = pos_w;
                src_nxt       = pos_w + 1'b1;
                out_valid_nxt = 1'b0;
                state_nxt     = ST_RDW;
              end
            end
            cle_pkg::FUNC_WRITE: begin
              if (pos_w >= cnt_w) begin
                out_st_nxt = cle_pkg::STAT_OOB;
              end else begin
                we = 1'b1;
              end
            end
            cle_pkg::FUNC_CLEAR: begin
              count_nxt   = '0;
              out_cnt_nxt = '0;
            end
            cle_pkg::FUNC_REMOVE_RG: begin
              if (pos_w >= cnt_w || endp_w > cnt_w || endp_w <= pos_w) begin
                out_st_nxt = cle_pkg::STAT_OOB;
              end else begin
                dst_nxt       = pos_w;
                src_nxt       = endp_w;
                rv_nxt        = '0;
                out_valid_nxt = 1'b0;
                state_nxt     = ST_SHIFT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_RDW: begin
        if (op_r == cle_pkg::FUNC_READ) begin
          out_valid_nxt = 1'b1;
          out_rv_nxt    = q_r;
          out_st_nxt    = cle_pkg::STAT_OK;
          out_cnt_nxt   = cle_pkg::CNT_W'(count_r);
          state_nxt     = ST_IDLE;
        end else begin
          rv_nxt    = q_r;
          state_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        // read of entry src overlaps write of the previous entry to dst
        re       = src_live;
        raddr    = src_r[AW-1:0];
        pend_nxt = src_live;
        if (src_live) begin
          src_nxt = src_r + 1'b1;
        end
        if (pend_r) begin
          we      = 1'b1;
          waddr   = dst_r[AW-1:0];
          wdata   = q_r;
          dst_nxt = dst_r + 1'b1;
        end
        if (!src_live && !pend_r) begin
          count_nxt     = CW'(dst_r);
          out_valid_nxt = 1'b1;
          out_rv_nxt    = rv_r;
          out_st_nxt    = cle_pkg::STAT_OK;
          out_cnt_nxt   = cle_pkg::CNT_W'(dst_r);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    src_r     <= src_nxt;
    dst_r     <= dst_nxt;
    rv_r      <= rv_nxt;
    out_rv_r  <= out_rv_nxt;
    out_st_r  <= out_st_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      q_r <= mem[raddr];
    end
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_read_value  = out_rv_r;
  assign out_status      = out_st_r;
  assign out_entry_count = out_cnt_r;

endmodule

FILE: sv/cle_chk.sv
// Port-level checker for compacting_list_engine, bound to the top level.
// Depends on cle_pkg.
module cle_chk #(
  parameter int CAPACITY = cle_pkg::DEF_CAPACITY
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_valid,
  input logic [cle_pkg::DATA_W-1:0]  out_read_value,
  input logic [cle_pkg::STAT_W-1:0]  out_status,
  input logic [cle_pkg::CNT_W-1:0]   out_entry_count
);

  // result only shows once the engine is free again
  a_res_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // every request gives a result next cycle or raises busy for a long op
  a_req_resp: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("request neither answered nor started");

  a_done_res: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("long op ended without result");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != cle_pkg::STAT_OK) |-> (out_read_value == '0))
    else $error("nonzero read value on error");

  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == cle_pkg::STAT_FULL)
      |-> (out_entry_count == cle_pkg::CNT_W'(CAPACITY)))
    else $error("full status with list not full");

endmodule

bind compacting_list_engine cle_chk #(.CAPACITY(CAPACITY)) u_cle_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_read_value  (out_read_value),
  .out_status      (out_status),
  .out_entry_count (out_entry_count)
);

FILE: dv/tb.sv
// Self-checking testbench for compacting_list_engine: directed and random requests,
// with an in-bench list predictor that checks every result field.
// Depends on cle_pkg and the compacting_list_engine RTL.
module tb;

  localparam int CAP          = cle_pkg::DEF_CAPACITY;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 80;

  localparam logic [cle_pkg::FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
  localparam logic [cle_pkg::FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [cle_pkg::DATA_W-1:0] read_value;
    logic [cle_pkg::STAT_W-1:0] status;
    logic [cle_pkg::CNT_W-1:0]  entry_count;
  } list_result_t;

  logic                       clk;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic [cle_pkg::FUNC_W-1:0] in_func;
  logic [cle_pkg::POS_W-1:0]  in_position;
  logic [cle_pkg::ENDP_W-1:0] in_end_position;
  logic [cle_pkg::DATA_W-1:0] in_new_value;
  logic                       out_valid;
  logic [cle_pkg::DATA_W-1:0] out_read_value;
  logic [cle_pkg::STAT_W-1:0] out_status;
  logic [cle_pkg::CNT_W-1:0]  out_entry_count;

  logic [cle_pkg::DATA_W-1:0] list_mem [CAP];
  int                         list_cnt;
  list_result_t               expected_q[$];
  int                         err_count;
  int                         cycle_cnt;
  bit                         no_idle;

  compacting_list_engine #(.CAPACITY(CAP)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_position     (in_position),
    .in_end_position (in_end_position),
    .in_new_value    (in_new_value),
    .out_valid       (out_valid),
    .out_read_value  (out_read_value),
    .out_status      (out_status),
    .out_entry_count (out_entry_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_cnt, expected_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic void shift_list(input int first, input int len);
    for (int i = first; i + len < list_cnt; i++) list_mem[i] = list_mem[i + len];
    for (int i = list_cnt - len; i < list_cnt; i++) list_mem[i] = '0;
    list_cnt -= len;
  endfunction

  function automatic list_result_t predict_list_op(input logic [cle_pkg::FUNC_W-1:0] f,
                                                   input logic [cle_pkg::POS_W-1:0]  p,
                                                   input logic [cle_pkg::ENDP_W-1:0] e,
                                                   input logic [cle_pkg::DATA_W-1:0] v);
    list_result_t r;
    int           pi;
    int           ei;
    r  = '0;
    pi = int'(p);
    ei = int'(e);
    case (f)
      cle_pkg::FUNC_APPEND: begin
        if (list_cnt >= CAP) r.status = cle_pkg::STAT_FULL;
        else begin
          list_mem[list_cnt] = v;
          list_cnt++;
        end
      end
      cle_pkg::FUNC_READ: begin
        if (pi >= list_cnt) r.status = cle_pkg::STAT_OOB;
        else r.read_value = list_mem[pi];
      end
      cle_pkg::FUNC_WRITE: begin
        if (pi >= list_cnt) r.status = cle_pkg::STAT_OOB;
        else list_mem[pi] = v;
      end
      cle_pkg::FUNC_REMOVE: begin
        if (pi >= list_cnt) r.status = cle_pkg::STAT_OOB;
        else begin
          r.read_value = list_mem[pi];
          shift_list(pi, 1);
        end
      end
      cle_pkg::FUNC_CLEAR: begin
        for (int i = 0; i < CAP; i++) list_mem[i] = '0;
        list_cnt = 0;
      end
      cle_pkg::FUNC_REMOVE_RG: begin
        if (pi >= list_cnt || ei > list_cnt || ei <= pi) r.status = cle_pkg::STAT_OOB;
        else shift_list(pi, ei - pi);
      end
      default: ;
    endcase
    r.entry_count = cle_pkg::CNT_W'(list_cnt);
    return r;
  endfunction

  // one request; start stays high across back-to-back requests
  task automatic send_cmd(input logic [cle_pkg::FUNC_W-1:0] f,
                          input logic [cle_pkg::POS_W-1:0]  p,
                          input logic [cle_pkg::ENDP_W-1:0] e,
                          input logic [cle_pkg::DATA_W-1:0] v);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    in_func         <= f;
    in_position     <= p;
    in_end_position <= e;
    in_new_value    <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q.push_back(predict_list_op(f, p, e, v));
  endtask

  task automatic wait_drain();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result rd=%h st=%0d cnt=%0d",
                                  out_read_value, out_status, out_entry_count));
      end else begin
        want = expected_q.pop_front();
        if (out_read_value !== want.read_value)
          report_mismatch($sformatf("read_value %h, want %h", out_read_value, want.read_value));
        if (out_status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_status, want.status));
        if (out_entry_count !== want.entry_count)
          report_mismatch($sformatf("entry_count %0d, want %0d",
                                    out_entry_count, want.entry_count));
      end
    end
  end

  function automatic logic [cle_pkg::DATA_W-1:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  task automatic test_empty_list();
    send_cmd(cle_pkg::FUNC_READ, 6'd0, 7'd0, '0);
    send_cmd(cle_pkg::FUNC_REMOVE, 6'd63, 7'd0, '0);
    send_cmd(cle_pkg::FUNC_WRITE, 6'd0, 7'd0, '1);
    send_cmd(cle_pkg::FUNC_REMOVE_RG, 6'd0, 7'd1, '0);
  endtask

  task automatic test_append_read_write();
    send_cmd(cle_pkg::FUNC_APPEND, 6'd0, 7'd0, '1);
    send_cmd(cle_pkg::FUNC_APPEND, 6'd63, 7'd127, '0);
    send_cmd(cle_pkg::FUNC_APPEND, 6'd0, 7'd0, 64'hA5A5_5A5A_C3C3_3C3C);
    send_cmd(cle_pkg::FUNC_APPEND, 6'd0, 7'd0, 64'h0000_0000_0000_0001);
    send_cmd(cle_pkg::FUNC_READ, 6'd0, 7'd0, '0);
    send_cmd(cle_pkg::FUNC_READ, 6'd3, 7'd0, '0);
    send_cmd(cle_pkg::FUNC_READ, 6'd4, 7'd0, '0);
    send_cmd(cle_pkg::FUNC_WRITE, 6'd1, 7'd0, 64'h8000_0000_0000_0000);
    send_cmd(cle_pkg::FUNC_WRITE, 6'd63, 7'd0, rand_word());
    send_cmd(cle_pkg::FUNC_READ, 6'd1, 7'd0, '0);
  endtask

  task automatic test_spare_codes();
    send_cmd(FUNC_SPARE_6, 6'd0, 7'd0, rand_word());
    send_cmd(FUNC_SPARE_7, 6'd63, 7'd127, '1);
  endtask

  task automatic test_bad_ranges();
    send_cmd(cle_pkg::FUNC_REMOVE_RG, 6'd2, 7'd2, '0);
    send_cmd(cle_pkg::FUNC_REMOVE_RG, 6'd0, 7'd5, '0);
    send_cmd(cle_pkg::FUNC_REMOVE_RG, 6'd0, 7'd127, '0);
    send_cmd(cle_pkg::FUNC_REMOVE_RG, 6'd4, 7'd4, '0);
  endtask

  task automatic test_removals();
    send_cmd(cle_pkg::FUNC_REMOVE_RG, 6'd1, 7'd3, '0);
    send_cmd(cle_pkg::FUNC_REMOVE, 6'd0, 7'd0, '0);
    send_cmd(cle_pkg::FUNC_REMOVE, 6'd0, 7'd0, '0);
  endtask

  task automatic test_clear();
    send_cmd(cle_pkg::FUNC_APPEND, 6'd0, 7'd0, rand_word());
    send_cmd(cle_pkg::FUNC_CLEAR, 6'd17, 7'd99, '1);
    send_cmd(cle_pkg::FUNC_READ, 6'd0, 7'd0, '0);
    send_cmd(cle_pkg::FUNC_APPEND, 6'd0, 7'd0, rand_word());
    send_cmd(cle_pkg::FUNC_READ, 6'd0, 7'd0, '0);
  endtask

  // fill to capacity, overflow, read and write the last slot, then a removal from the head of the full list
  task automatic test_fill_to_capacity(input int rounds);
    int p;
    for (int r = 0; r < rounds; r++) begin
      no_idle = (r % 2 == 1);
      send_cmd(cle_pkg::FUNC_CLEAR, 6'($urandom()), 7'($urandom()), rand_word());
      while (list_cnt < CAP)
        send_cmd(cle_pkg::FUNC_APPEND, 6'($urandom()), 7'($urandom()), rand_word());
      send_cmd(cle_pkg::FUNC_APPEND, 6'd0, 7'd0, rand_word());
      send_cmd(cle_pkg::FUNC_READ, 6'd63, 7'd0, '0);
      send_cmd(cle_pkg::FUNC_WRITE, 6'd63, 7'd0, rand_word());
      case (r % 3)
        0: send_cmd(cle_pkg::FUNC_REMOVE, 6'd0, 7'd0, '0);
        1: send_cmd(cle_pkg::FUNC_REMOVE_RG, 6'd0, 7'd64, '0);
        default: send_cmd(cle_pkg::FUNC_REMOVE_RG, 6'd0, 7'd1, '0);
      endcase
      for (int k = 0; k < 8 && list_cnt > 0; k++) begin
        p = $urandom_range(0, list_cnt - 1);
        send_cmd(cle_pkg::FUNC_READ, 6'(p), 7'($urandom()), '0);
      end
    end
    no_idle = 1'b0;
  endtask

  task automatic test_random_mix(input int n_items);
    int                         sel;
    int                         p;
    int                         e;
    logic [cle_pkg::FUNC_W-1:0] f;
    bit                         noise;
    for (int i = 0; i < n_items; i++) begin
      if (i % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (i % 400 == 399) wait_drain();
      sel   = $urandom_range(0, 99);
      noise = ($urandom_range(0, 99) < 15) || (list_cnt == 0);
      if (sel < 34) f = cle_pkg::FUNC_APPEND;
      else if (sel < 50) f = cle_pkg::FUNC_READ;
      else if (sel < 65) f = cle_pkg::FUNC_WRITE;
      else if (sel < 82) f = cle_pkg::FUNC_REMOVE;
      else if (sel < 95) f = cle_pkg::FUNC_REMOVE_RG;
      else if (sel < 98) f = cle_pkg::FUNC_CLEAR;
      else f = ($urandom_range(0, 1) != 0) ? FUNC_SPARE_6 : FUNC_SPARE_7;
      if (noise) begin
        p = $urandom_range(0, 63);
        e = $urandom_range(0, 127);
      end else begin
        p = $urandom_range(0, list_cnt - 1);
        e = (f == cle_pkg::FUNC_REMOVE_RG)
              ? $urandom_range(p + 1, (p + 4 < list_cnt) ? p + 4 : list_cnt)
              : $urandom_range(0, 127);
      end
      send_cmd(f, 6'(p), 7'(e), rand_word());
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_func         = '0;
    in_position     = '0;
    in_end_position = '0;
    in_new_value    = '0;
    err_count       = 0;
    cycle_cnt       = 0;
    no_idle         = 1'b0;
    list_cnt        = 0;
    for (int i = 0; i < CAP; i++) list_mem[i] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list();
    test_append_read_write();
    test_spare_codes();
    test_bad_ranges();
    test_removals();
    test_clear();
    wait_drain();
    test_fill_to_capacity(3);
    wait_drain();
    test_random_mix(1650);
    wait_drain();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
